// File: rtl/arc_length_path_history_buffer_unit_macros.svh
// Assertion macros for the arc-length path history buffer.
`ifndef ARC_LENGTH_PATH_HISTORY_BUFFER_UNIT_MACROS_SVH
`define ARC_LENGTH_PATH_HISTORY_BUFFER_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ALPB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ALPB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ALPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/alpb_pkg.sv
// Shared widths, codes and reset values of the arc-length path history buffer.
package alpb_pkg;

	// Coordinate and arithmetic widths
	localparam int COORD_BITS = 24;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SQ_CNT_W   = $clog2(ROOT_W);

	// Register and result widths
	localparam int ARC_W      = 32;
	localparam int INTERVAL_W = 24;
	localparam int LINK_CNT_W = 6;
	localparam int LINK_LEN_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_OUT_W  = 9;
	localparam int STATUS_W   = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [STATUS_W-1:0]          status_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

	// Result status codes
	localparam status_t STATUS_SEEDED   = 2'd0;
	localparam status_t STATUS_RECORDED = 2'd1;
	localparam status_t STATUS_IGNORED  = 2'd2;

	// Configuration register indexes
	localparam cfg_idx_t CFG_SAMPLE_INTERVAL = 2'd0;
	localparam cfg_idx_t CFG_MAX_ARC_LENGTH  = 2'd1;
	localparam cfg_idx_t CFG_LINK_COUNT      = 2'd2;
	localparam cfg_idx_t CFG_LINK_LENGTH     = 2'd3;

	// Register reset values
	localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 24'd3277;
	localparam logic [ARC_W-1:0]      RST_MAX_ARC_LENGTH  = 32'd327680;
	localparam logic [LINK_CNT_W-1:0] RST_LINK_COUNT      = 6'd4;
	localparam logic [LINK_LEN_W-1:0] RST_LINK_LENGTH     = 24'd32768;

endpackage

// File: rtl/alpb_in_if.sv
// Sample channel: valid/ready with one 3D position.
interface alpb_in_if;
	import alpb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;

	modport source (output valid, pos_x, pos_y, pos_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// File: rtl/alpb_out_if.sv
// Result channel: valid/ready with the per-sample history status.
interface alpb_out_if;
	import alpb_pkg::*;

	logic                 valid;
	logic                 ready;
	status_t              status;
	logic [CNT_OUT_W-1:0] points_held;
	logic [CNT_OUT_W-1:0] dropped_count;
	logic [ARC_W-1:0]     arc_length;
	logic                 ready_res;
	logic                 overflowed;

	modport source (output valid, status, points_held, dropped_count, arc_length,
		ready_res, overflowed, input ready);
	modport sink   (input valid, status, points_held, dropped_count, arc_length,
		ready_res, overflowed, output ready);
endinterface

// File: rtl/alpb_isqrt.sv
// Bit-serial integer square root: one result bit per cycle, floor of the root.
module alpb_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [alpb_pkg::SUM_W-1:0] radicand,
	output logic                       done,
	output logic [alpb_pkg::ROOT_W-1:0] root
);
	import alpb_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]    rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	// Bring down the next two radicand bits and try the next root bit
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// Flag the last iteration for one cycle
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQ_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// File: rtl/alpb_seg_mem.sv
// Segment-length store: one write port, one read port with registered data.
module alpb_seg_mem #(
	parameter  int DEPTH = 256,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [alpb_pkg::ROOT_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [alpb_pkg::ROOT_W-1:0] rdata
);
	import alpb_pkg::*;

	logic [ROOT_W-1:0] mem [DEPTH];
	logic [ROOT_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/arc_length_path_history_buffer_unit.sv
// Top level of the arc-length path history buffer: sequencer, registers and output stage.
// Usage:
//   sample (valid/ready) takes one 3D position in signed Q8.16 metres per transfer.
//   result (valid/ready) returns one status item per sample, in order.
//   cfg_we/cfg_idx/cfg_data write sample_interval, max_arc_length, link_count and
//   link_length; write them only while no sample is in flight.
// Sequence:
//   The first sample after reset seeds the history and yields its result after
//   the readiness product. Every later sample runs three squarings on the shared
//   multiplier, a bit-serial square root, then store, trim check and readiness
//   product, plus one segment-memory read and subtract per point trimmed and one
//   for the drop forced by a full store.
//   A sample that is too close skips the store and the trim check.
//   sample.ready is high only while the sequencer is idle; one sample at a time.
// Reset:
//   arst_n clears the history (empty, unseeded), the arc length and the output
//   stage, and loads the register defaults. No memory clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next sample is still
//   taken, and its result waits until the previous one has been transferred.
`include "arc_length_path_history_buffer_unit_macros.svh"

module arc_length_path_history_buffer_unit #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [alpb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [alpb_pkg::CFG_DATA_W-1:0] cfg_data,
	alpb_in_if.sink                        sample,
	alpb_out_if.source                     result
);
	import alpb_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
	localparam logic [1:0]    LAST_COMP = 2'd2;

	// Sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SEED  = 4'd1;
	localparam logic [3:0] ST_DIFF  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_CMP   = 4'd6;
	localparam logic [3:0] ST_DSUB  = 4'd7;
	localparam logic [3:0] ST_STORE = 4'd8;
	localparam logic [3:0] ST_TRIM  = 4'd9;
	localparam logic [3:0] ST_NEED  = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0] state_q;

	// Configuration registers
	logic [INTERVAL_W-1:0] interval_q;
	logic [ARC_W-1:0]      max_arc_q;
	logic [LINK_CNT_W-1:0] link_count_q;
	logic [LINK_LEN_W-1:0] link_length_q;

	// History state
	logic          seeded_q;
	coord_t        last_x_q, last_y_q, last_z_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] held_q;
	logic [ARC_W-1:0] total_q;

	// Per-sample working registers
	coord_t            pos_x_q, pos_y_q, pos_z_q;
	logic [1:0]        comp_q;
	logic [DIFF_W-1:0] diff_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  acc_q;
	status_t           status_q;
	logic [CW-1:0]     dropped_q;
	logic              over_q;
	logic              stored_q;

	// Output stage
	logic                 res_valid_q;
	status_t              res_status_q;
	logic [CNT_OUT_W-1:0] res_held_q;
	logic [CNT_OUT_W-1:0] res_dropped_q;
	logic [ARC_W-1:0]     res_arc_q;
	logic                 res_ready_q;
	logic                 res_over_q;

	// Combinational helpers
	logic                    accept;
	logic                    res_free;
	coord_t                  cur_a, cur_b;
	logic signed [DIFF_W-1:0] sdiff;
	logic [DIFF_W-1:0]       mul_a, mul_b;
	logic [PROD_W-1:0]       mul_p;
	logic [SUM_W-1:0]        acc_sum;
	logic                    sq_start, sq_done;
	logic [ROOT_W-1:0]       sq_root;
	logic [ROOT_W-1:0]       seg_rd;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [ROOT_W-1:0]       mem_wdata;
	logic [AW-1:0]           next_oldest;
	logic [CW:0]             slot_sum;
	logic [AW-1:0]           slot;
	logic [ARC_W:0]          arc_add;
	logic [ARC_W-1:0]        arc_sat;
	logic [ARC_W-1:0]        seg_ext;
	logic                    far_enough;

	assign accept   = sample.valid && sample.ready;
	assign res_free = !res_valid_q || result.ready;

	// Pick the coordinate pair for the current axis
	always_comb begin
		unique case (comp_q)
			2'd0:    begin cur_a = pos_x_q; cur_b = last_x_q; end
			2'd1:    begin cur_a = pos_y_q; cur_b = last_y_q; end
			default: begin cur_a = pos_z_q; cur_b = last_z_q; end
		endcase
		sdiff = DIFF_W'(cur_a) - DIFF_W'(cur_b);
	end

	// Shared multiplier: squares of the axis differences, then the readiness threshold
	always_comb begin
		if (state_q == ST_NEED) begin
			mul_a = (link_count_q == '0) ? '0
				: DIFF_W'(link_count_q - LINK_CNT_W'(1));
			mul_b = DIFF_W'(link_length_q);
		end else begin
			mul_a = diff_q;
			mul_b = diff_q;
		end
		mul_p = mul_a * mul_b;
	end

	assign acc_sum  = acc_q + SUM_W'(prod_q);
	assign sq_start = (state_q == ST_ACC) && (comp_q == LAST_COMP);

	alpb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_sum),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Ring addressing
	always_comb begin
		next_oldest = (oldest_q == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
		slot_sum    = (CW+1)'(oldest_q) + (CW+1)'(held_q);
		if (slot_sum >= (CW+1)'(HISTORY_DEPTH)) begin
			slot = AW'(slot_sum - (CW+1)'(HISTORY_DEPTH));
		end else begin
			slot = AW'(slot_sum);
		end
	end

	// Arc-length arithmetic
	always_comb begin
		arc_add    = (ARC_W+1)'(total_q) + (ARC_W+1)'(sq_root);
		arc_sat    = arc_add[ARC_W] ? '1 : arc_add[ARC_W-1:0];
		seg_ext    = ARC_W'(seg_rd);
		far_enough = (sq_root >= ROOT_W'(interval_q));
	end

	// Segment memory write: zero for the seed point, the distance for a stored point
	always_comb begin
		mem_we    = (state_q == ST_SEED) || (state_q == ST_STORE);
		mem_waddr = (state_q == ST_SEED) ? oldest_q : slot;
		mem_wdata = (state_q == ST_SEED) ? '0 : sq_root;
	end

	// The read port always looks at the second-oldest entry
	alpb_seg_mem #(
		.DEPTH (HISTORY_DEPTH)
	) u_seg_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (next_oldest),
		.rdata (seg_rd)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= RST_SAMPLE_INTERVAL;
			max_arc_q     <= RST_MAX_ARC_LENGTH;
			link_count_q  <= RST_LINK_COUNT;
			link_length_q <= RST_LINK_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SAMPLE_INTERVAL: interval_q    <= cfg_data[INTERVAL_W-1:0];
				CFG_MAX_ARC_LENGTH:  max_arc_q     <= cfg_data[ARC_W-1:0];
				CFG_LINK_COUNT:      link_count_q  <= cfg_data[LINK_CNT_W-1:0];
				CFG_LINK_LENGTH:     link_length_q <= cfg_data[LINK_LEN_W-1:0];
				default:             ;
			endcase
		end
	end

	// Sequencer and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			oldest_q    <= '0;
			held_q      <= '0;
			total_q     <= '0;
			comp_q      <= '0;
			dropped_q   <= '0;
			over_q      <= 1'b0;
			stored_q    <= 1'b0;
			status_q    <= STATUS_SEEDED;
			res_valid_q <= 1'b0;
		end else begin
			// Raise valid when a result is loaded, drop it once transferred
			if ((state_q == ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						comp_q    <= '0;
						dropped_q <= '0;
						over_q    <= 1'b0;
						stored_q  <= 1'b0;
						state_q   <= seeded_q ? ST_DIFF : ST_SEED;
					end
				end
				ST_SEED: begin
					held_q   <= CW'(1);
					last_x_q <= pos_x_q;
					last_y_q <= pos_y_q;
					last_z_q <= pos_z_q;
					seeded_q <= 1'b1;
					status_q <= STATUS_SEEDED;
					state_q  <= ST_NEED;
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC: begin
					// Advance to the next axis, or hand the sum to the root unit
					if (comp_q == LAST_COMP) begin
						state_q <= ST_SQRT;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= ST_DIFF;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!far_enough) begin
						status_q <= STATUS_IGNORED;
						state_q  <= ST_NEED;
					end else if (held_q == DEPTH_C) begin
						// Full store: drop the oldest point before storing
						over_q  <= 1'b1;
						state_q <= ST_DSUB;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_DSUB: begin
					total_q   <= (total_q >= seg_ext) ? total_q - seg_ext : '0;
					oldest_q  <= next_oldest;
					held_q    <= held_q - CW'(1);
					dropped_q <= dropped_q + CW'(1);
					state_q   <= stored_q ? ST_TRIM : ST_STORE;
				end
				ST_STORE: begin
					held_q   <= held_q + CW'(1);
					total_q  <= arc_sat;
					last_x_q <= pos_x_q;
					last_y_q <= pos_y_q;
					last_z_q <= pos_z_q;
					stored_q <= 1'b1;
					status_q <= STATUS_RECORDED;
					state_q  <= ST_TRIM;
				end
				ST_TRIM: begin
					if ((total_q > max_arc_q) && (held_q > CW'(1))) begin
						state_q <= ST_DSUB;
					end else begin
						state_q <= ST_NEED;
					end
				end
				ST_NEED: state_q <= ST_DONE;
				ST_DONE: begin
					// Hold until the output register is free
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q <= sample.pos_x;
			pos_y_q <= sample.pos_y;
			pos_z_q <= sample.pos_z;
			acc_q   <= '0;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= sdiff[DIFF_W-1] ? DIFF_W'(-sdiff) : DIFF_W'(sdiff);
		end
		if ((state_q == ST_MUL) || (state_q == ST_NEED)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_sum;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && res_free) begin
			res_status_q  <= status_q;
			res_held_q    <= CNT_OUT_W'(held_q);
			res_dropped_q <= CNT_OUT_W'(dropped_q);
			res_arc_q     <= total_q;
			res_ready_q   <= (PROD_W'(total_q) >= prod_q);
			res_over_q    <= over_q;
		end
	end

	assign sample.ready         = (state_q == ST_IDLE);
	assign result.valid         = res_valid_q;
	assign result.status        = res_status_q;
	assign result.points_held   = res_held_q;
	assign result.dropped_count = res_dropped_q;
	assign result.arc_length    = res_arc_q;
	assign result.ready_res     = res_ready_q;
	assign result.overflowed    = res_over_q;

	// Checks
	`ALPB_ASSERT_ALWAYS(a_held_bound, clk, arst_n, held_q <= DEPTH_C,
		"history count above depth")
	`ALPB_ASSERT_IMPLY(a_unseeded_empty, clk, arst_n, !seeded_q,
		(held_q == '0) && (total_q == '0), "unseeded history not empty")
	`ALPB_ASSERT_IMPLY(a_root_in_wait, clk, arst_n, sq_done, state_q == ST_SQRT,
		"root finished outside its wait state")
	`ALPB_ASSERT_NEXT(a_drop_count, clk, arst_n, state_q == ST_DSUB,
		held_q == $past(held_q) - CW'(1), "drop did not shrink the history by one")

endmodule

// File: tb/arc_length_path_history_buffer_unit_tb.sv
// Self-checking testbench for the arc-length path history buffer: predicts every result.
module arc_length_path_history_buffer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import alpb_pkg::*;

	typedef longint unsigned u64_t;

	localparam int     HIST_DEPTH     = 256;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     PRINT_LIMIT    = 40;
	localparam coord_t COORD_MAX      = 24'h7FFFFF;
	localparam coord_t COORD_MIN      = 24'h800000;
	localparam u64_t   ARC_SAT        = 64'hFFFF_FFFF;

	// One expected result of the history buffer
	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] held;
		logic [CNT_OUT_W-1:0] dropped;
		logic [ARC_W-1:0]     arc;
		logic                 rdy;
		logic                 ovf;
	} track_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	cfg_idx_t              cfg_idx  = CFG_SAMPLE_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	alpb_in_if  sample_bus ();
	alpb_out_if result_bus ();

	arc_length_path_history_buffer_unit #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample   (sample_bus),
		.result   (result_bus)
	);

	// Predictor copy of the registers and the history state
	logic [INTERVAL_W-1:0] cfg_interval = RST_SAMPLE_INTERVAL;
	logic [ARC_W-1:0]      cfg_max_arc  = RST_MAX_ARC_LENGTH;
	logic [LINK_CNT_W-1:0] cfg_links    = RST_LINK_COUNT;
	logic [LINK_LEN_W-1:0] cfg_link_len = RST_LINK_LENGTH;

	bit          trk_seeded = 1'b0;
	coord_t      trk_last_x = '0;
	coord_t      trk_last_y = '0;
	coord_t      trk_last_z = '0;
	u64_t        seg_store [HIST_DEPTH];
	int unsigned trk_oldest = 0;
	int unsigned trk_held   = 0;
	u64_t        trk_arc    = 0;

	track_result_t expected_results [$];
	int            mismatch_count = 0;
	int            idle_cycles    = 0;
	int            send_idle_pct  = 0;
	int            recv_idle_pct  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact floor of the square root, one result bit at a time
	function automatic u64_t floor_root(u64_t n);
		u64_t root;
		u64_t trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (u64_t'(1) << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic u64_t axis_sq(coord_t a, coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return u64_t'(d) * u64_t'(d);
	endfunction

	// Remove the oldest point and the segment that led to its successor
	function automatic void drop_oldest_point();
		int unsigned nxt;
		nxt = (trk_oldest + 1) % HIST_DEPTH;
		trk_arc = (trk_arc >= seg_store[nxt]) ? trk_arc - seg_store[nxt] : 0;
		trk_oldest = nxt;
		trk_held--;
	endfunction

	function automatic track_result_t predict_sample(coord_t x, coord_t y, coord_t z);
		track_result_t r;
		u64_t          seg_dist;
		u64_t          need;
		int unsigned   slot;
		int unsigned   drops;
		r = '0;
		drops = 0;
		if (!trk_seeded) begin
			seg_store[trk_oldest] = 0;
			trk_held = 1;
			trk_seeded = 1'b1;
			{trk_last_x, trk_last_y, trk_last_z} = {x, y, z};
			r.status = STATUS_SEEDED;
		end else begin
			seg_dist = floor_root(axis_sq(x, trk_last_x) + axis_sq(y, trk_last_y)
				+ axis_sq(z, trk_last_z));
			if (seg_dist >= u64_t'(cfg_interval)) begin
				// make room first when the store is full
				if (trk_held >= HIST_DEPTH) begin
					drop_oldest_point();
					drops++;
					r.ovf = 1'b1;
				end
				slot = (trk_oldest + trk_held) % HIST_DEPTH;
				seg_store[slot] = seg_dist;
				trk_held++;
				trk_arc += seg_dist;
				if (trk_arc > ARC_SAT)
					trk_arc = ARC_SAT;
				{trk_last_x, trk_last_y, trk_last_z} = {x, y, z};
				// trim the tail back under the arc-length limit
				while (trk_arc > u64_t'(cfg_max_arc) && trk_held > 1) begin
					drop_oldest_point();
					drops++;
				end
				r.status = STATUS_RECORDED;
			end else begin
				r.status = STATUS_IGNORED;
			end
		end
		need = (cfg_links == 0) ? 0 : (u64_t'(cfg_links) - 1) * u64_t'(cfg_link_len);
		r.held    = CNT_OUT_W'(trk_held);
		r.dropped = CNT_OUT_W'(drops);
		r.arc     = ARC_W'(trk_arc);
		r.rdy     = (trk_arc >= need);
		return r;
	endfunction

	function automatic coord_t shift_coord(coord_t base, longint off);
		longint v;
		v = longint'(base) + off;
		if (v > longint'(COORD_MAX))
			v = longint'(COORD_MAX);
		else if (v < longint'(COORD_MIN))
			v = longint'(COORD_MIN);
		return coord_t'(v);
	endfunction

	function automatic longint rand_offset(longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	task automatic report_mismatch(string what, u64_t got, u64_t want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] result mismatch on %s: got %0d, expected %0d",
				$realtime, what, got, want);
	endtask

	// Offer one sample, hold it until the transfer, then record the prediction
	task automatic send_sample(longint x_in, longint y_in, longint z_in);
		coord_t x;
		coord_t y;
		coord_t z;
		x = coord_t'(x_in);
		y = coord_t'(y_in);
		z = coord_t'(z_in);
		@(negedge clk);
		// idle each cycle with the sender's idle share
		while ($urandom_range(99) < send_idle_pct) begin
			sample_bus.valid = 1'b0;
			@(negedge clk);
		end
		sample_bus.valid = 1'b1;
		sample_bus.pos_x = x;
		sample_bus.pos_y = y;
		sample_bus.pos_z = z;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		expected_results = {expected_results, predict_sample(x, y, z)};
	endtask

	task automatic send_jitter(longint span);
		send_sample(shift_coord(trk_last_x, rand_offset(span)),
			shift_coord(trk_last_y, rand_offset(span)),
			shift_coord(trk_last_z, rand_offset(span)));
	endtask

	// Mostly steps around the sample interval, some on it or just below, some noise
	task automatic send_walk_step();
		int     mode;
		longint off;
		longint d [3];
		mode = $urandom_range(99);
		if (mode < 10) begin
			send_sample(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
		end else if (mode < 22) begin
			off = longint'(cfg_interval) - longint'($urandom_range(1));
			if ($urandom_range(1))
				off = -off;
			d = '{0, 0, 0};
			d[$urandom_range(2)] = off;
			send_sample(shift_coord(trk_last_x, d[0]), shift_coord(trk_last_y, d[1]),
				shift_coord(trk_last_z, d[2]));
		end else begin
			send_jitter(longint'(cfg_interval) * $urandom_range(1, 4) / 2 + 8);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	task automatic apply_config(logic [31:0] interval, logic [31:0] max_arc,
		logic [31:0] links, logic [31:0] link_len);
		write_reg(CFG_SAMPLE_INTERVAL, interval);
		write_reg(CFG_MAX_ARC_LENGTH, max_arc);
		write_reg(CFG_LINK_COUNT, links);
		write_reg(CFG_LINK_LENGTH, link_len);
		cfg_interval = interval[INTERVAL_W-1:0];
		cfg_max_arc  = max_arc;
		cfg_links    = links[LINK_CNT_W-1:0];
		cfg_link_len = link_len[LINK_LEN_W-1:0];
	endtask

	// Drop valid and hold until every result is back and the block is quiet
	task automatic wait_idle();
		@(negedge clk);
		sample_bus.valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic pick_random_config();
		logic [31:0] interval;
		logic [31:0] max_arc;
		logic [31:0] links;
		logic [31:0] link_len;
		case ($urandom_range(3))
			0: interval = 0;
			1: interval = $urandom_range(1, 4000);
			2: interval = $urandom_range(4001, 200000);
			default: interval = $urandom();
		endcase
		if ($urandom_range(9) == 0)
			interval = 32'hFFFF_FFFF;
		case ($urandom_range(4))
			0: max_arc = 0;
			1: max_arc = 32'hFFFF_FFFF;
			2: max_arc = $urandom();
			default: max_arc = (interval[23:0] + 1) * $urandom_range(1, 40);
		endcase
		case ($urandom_range(3))
			0: links = 0;
			1: links = 63;
			default: links = $urandom_range(1, 32);
		endcase
		case ($urandom_range(3))
			0: link_len = 0;
			1: link_len = 32'hFFFF_FFFF;
			default: link_len = $urandom_range(1, 300000);
		endcase
		// bits above each register's width must be ignored
		interval[31:24]  = 8'($urandom_range(255));
		link_len[31:24]  = 8'($urandom_range(255));
		links[31:6]      = 26'($urandom());
		apply_config(interval, max_arc, links, link_len);
	endtask

	task automatic test_directed_cases();
		// seed, then steps on both sides of the default interval
		send_sample(0, 0, 0);
		send_sample(0, 0, 0);
		send_sample(3276, 0, 0);
		send_sample(3277, 0, 0);
		send_sample(COORD_MIN, COORD_MIN, COORD_MIN);
		send_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		send_sample(COORD_MAX, COORD_MIN, 0);
		send_sample(-1, -1, -1);
		send_sample(0, 3000, 2000);
		wait_idle();
		// zero interval records repeats; zero link count is always ready
		apply_config(32'h5A00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 0);
		send_sample(0, 3000, 2000);
		send_sample(COORD_MIN, COORD_MAX, COORD_MIN);
		wait_idle();
		// widest interval and threshold
		apply_config(32'h00FF_FFFF, 32'hFFFF_FFFF, 63, 32'h00FF_FFFF);
		send_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		send_sample(COORD_MIN, COORD_MAX, COORD_MAX);
		send_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		send_sample(COORD_MIN + 1, COORD_MAX, COORD_MAX);
		wait_idle();
		apply_config(32'(RST_SAMPLE_INTERVAL), RST_MAX_ARC_LENGTH, 32'(RST_LINK_COUNT),
			32'(RST_LINK_LENGTH));
		send_sample(4096, -4096, 65536);
		send_sample(COORD_MAX, 0, COORD_MIN);
		wait_idle();
	endtask

	task automatic test_store_overflow();
		// corner-to-corner jumps saturate the arc length and overfill the store
		apply_config(32'hC300_0000, 32'hFFFF_FFFF, 32, 32'h00FF_FFFF);
		for (int i = 0; i < 300; i++) begin
			if (i % 2 == 0)
				send_sample(shift_coord(COORD_MIN, longint'($urandom_range(4095))),
					shift_coord(COORD_MIN, longint'($urandom_range(4095))),
					shift_coord(COORD_MIN, longint'($urandom_range(4095))));
			else
				send_sample(shift_coord(COORD_MAX, -longint'($urandom_range(4095))),
					shift_coord(COORD_MAX, -longint'($urandom_range(4095))),
					shift_coord(COORD_MAX, -longint'($urandom_range(4095))));
		end
		wait_idle();
		// full store and zero limit: one forced drop plus a complete trim
		apply_config(0, 0, 2, 1);
		send_sample(COORD_MIN, COORD_MAX, 0);
		send_sample(COORD_MAX, COORD_MIN, -1);
		wait_idle();
	endtask

	task automatic test_bulk_trim();
		apply_config(32'h7700_0000, 32'hFFFF_FFFF, 10, 8000);
		repeat (200) send_jitter(16384);
		wait_idle();
		// a much lower limit removes many points at once
		apply_config(16, 32'(trk_arc >> $urandom_range(1, 4)), 5, 65536);
		repeat (30) send_jitter(16384);
		wait_idle();
		apply_config(16, 0, 1, 65536);
		repeat (20) send_jitter(16384);
		wait_idle();
	endtask

	task automatic test_random_walk(int count);
		while (count > 0) begin
			pick_random_config();
			for (int i = 0; i < 60 && count > 0; i++, count--)
				send_walk_step();
			wait_idle();
		end
	endtask

	// Receiver stalls
	always @(negedge clk)
		result_bus.ready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	// Compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		track_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transfer", result_bus.arc_length, 0);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (result_bus.status !== want.status)
					report_mismatch("status", result_bus.status, want.status);
				if (result_bus.points_held !== want.held)
					report_mismatch("points_held", result_bus.points_held, want.held);
				if (result_bus.dropped_count !== want.dropped)
					report_mismatch("dropped_count", result_bus.dropped_count, want.dropped);
				if (result_bus.arc_length !== want.arc)
					report_mismatch("arc_length", result_bus.arc_length, want.arc);
				if (result_bus.ready_res !== want.rdy)
					report_mismatch("ready_res", result_bus.ready_res, want.rdy);
				if (result_bus.overflowed !== want.ovf)
					report_mismatch("overflowed", result_bus.overflowed, want.ovf);
			end
		end
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		sample_bus.valid = 1'b0;
		sample_bus.pos_x = '0;
		sample_bus.pos_y = '0;
		sample_bus.pos_z = '0;
		foreach (seg_store[i])
			seg_store[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles lightly, receiver heavily
		send_idle_pct = 28;
		recv_idle_pct = 63;
		test_directed_cases();
		test_store_overflow();
		test_random_walk(180);

		// and the other way round
		send_idle_pct = 63;
		recv_idle_pct = 28;
		test_bulk_trim();
		test_random_walk(250);

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_walk(250);

		wait_idle();
		repeat (64) @(negedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: arc_length_path_history_buffer_unit.f
+incdir+rtl
rtl/alpb_pkg.sv
rtl/alpb_in_if.sv
rtl/alpb_out_if.sv
rtl/alpb_isqrt.sv
rtl/alpb_seg_mem.sv
rtl/arc_length_path_history_buffer_unit.sv
tb/arc_length_path_history_buffer_unit_tb.sv
